@@ rtl/core/h3th_pkg.sv @@
// h3th_pkg: types and fixed constants for the h3 tabulation hash
// holds the item structs, the internal op word and its kind codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package h3th_pkg;

  localparam int BYTE_W = 8;
  localparam int TIDX_W = 12;
  localparam int WORD_W = 32;
  localparam int BASE_W = 13;
  localparam int IDX_W  = 14;

  localparam logic FUNC_HASH  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic              func;
    logic              restart;
    logic [BYTE_W-1:0] key_byte;
    logic [TIDX_W-1:0] table_index;
    logic [WORD_W-1:0] table_word;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] hash_value;
    logic              overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_HASH  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SKIP  = 2'd2,
    OP_OVF   = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic              restart;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } op_t;

endpackage

`default_nettype wire

@@ rtl/core/h3th_fifo.sv @@
// h3th_fifo: small register queue with count, used for ops and results
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module h3th_fifo #(
  parameter int W     = 1,
  parameter int DEPTH = 4,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [W-1:0]  wr_data,
  input  wire logic          rd_en,
  output logic      [W-1:0]  rd_data,
  output logic               full,
  output logic               empty,
  output logic      [CW-1:0] count
);

  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/h3th_front.sv @@
// h3th_front: accepts words, tracks the running base and classifies each word
// into a table op; depends on h3th_pkg
`timescale 1ns / 1ps
`default_nettype none

module h3th_front #(
  parameter int TABLE_WORDS = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire h3th_pkg::in_item_t item,
  output h3th_pkg::op_t           op
);

  localparam logic [h3th_pkg::IDX_W:0] TW_L = (h3th_pkg::IDX_W + 1)'(TABLE_WORDS);

  logic [h3th_pkg::BASE_W-1:0] next_base_r, next_base_nxt;
  logic [h3th_pkg::BASE_W-1:0] base;
  logic [h3th_pkg::IDX_W-1:0]  idx;
  logic [h3th_pkg::IDX_W-1:0]  idx_inc;
  logic [h3th_pkg::IDX_W-1:0]  waddr;
  logic                        idx_ok;
  logic                        waddr_ok;

  always_comb begin
    base     = item.restart ? '0 : next_base_r;
    idx      = h3th_pkg::IDX_W'(base) + h3th_pkg::IDX_W'(item.key_byte);
    idx_inc  = idx + h3th_pkg::IDX_W'(1);
    waddr    = h3th_pkg::IDX_W'(item.table_index);
    idx_ok   = ({1'b0, idx} < TW_L);
    waddr_ok = ({1'b0, waddr} < TW_L);

    next_base_nxt = next_base_r;
    op.restart    = 1'b0;
    op.data       = item.table_word;
    op.addr       = waddr;
    if (item.func == h3th_pkg::FUNC_WRITE) begin
      op.kind = waddr_ok ? h3th_pkg::OP_WRITE : h3th_pkg::OP_SKIP;
    end else if (idx_ok) begin
      op.kind    = h3th_pkg::OP_HASH;
      op.restart = item.restart;
      op.addr    = idx;
      if (accept) begin
        next_base_nxt = idx_inc[h3th_pkg::BASE_W-1:0];
      end
    end else begin
      op.kind = h3th_pkg::OP_OVF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_base_r <= '0;
    end else begin
      next_base_r <= next_base_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/h3th_back.sv @@
// h3th_back: table memory and running hash; issues ops against the table
// and produces one result word per op; depends on h3th_pkg
`timescale 1ns / 1ps
`default_nettype none

module h3th_back #(
  parameter int TABLE_WORDS = 4096,
  parameter int OUT_DEPTH   = 4,
  parameter int CW          = $clog2(OUT_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire h3th_pkg::op_t      op,
  input  wire logic              op_empty,
  output logic                   op_pop,
  input  wire logic [CW-1:0]     out_count,
  output logic                   res_push,
  output h3th_pkg::out_item_t     res
);

  localparam int AW = $clog2(TABLE_WORDS);

  logic [h3th_pkg::WORD_W-1:0] table_r [TABLE_WORDS];
  logic [h3th_pkg::WORD_W-1:0] rdata_r;
  logic [h3th_pkg::WORD_W-1:0] hash_r, hash_nxt;
  logic                        s_v_r;
  h3th_pkg::op_kind_t          s_kind_r;
  logic                        s_restart_r;
  logic [AW-1:0]               addr;
  logic [CW:0]                 credit_used;

  assign addr        = op.addr[AW-1:0];
  assign credit_used = {1'b0, out_count} + (CW + 1)'(s_v_r);
  assign op_pop      = !op_empty && (credit_used < (CW + 1)'(OUT_DEPTH));
  assign res_push    = s_v_r;

  always_comb begin
    hash_nxt     = hash_r;
    res.overflow = 1'b0;
    case (s_kind_r)
      h3th_pkg::OP_HASH: begin
        hash_nxt = (s_restart_r ? '0 : hash_r) ^ rdata_r;
      end
      h3th_pkg::OP_OVF: begin
        res.overflow = 1'b1;
      end
      default: begin
        hash_nxt = hash_r;
      end
    endcase
    if (!s_v_r) begin
      hash_nxt = hash_r;
    end
    res.hash_value = hash_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r  <= 1'b0;
      hash_r <= '0;
    end else begin
      s_v_r  <= op_pop;
      hash_r <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      s_kind_r    <= op.kind;
      s_restart_r <= op.restart;
    end
  end

  // table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (op_pop && op.kind == h3th_pkg::OP_WRITE) begin
      table_r[addr] <= op.data;
    end
    if (op_pop) begin
      rdata_r <= table_r[addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/h3_tabulation_hash.sv @@
// h3_tabulation_hash: top level of the byte-serial h3 tabulation hash
// depends on h3th_pkg, h3th_front, h3th_fifo and h3th_back
//
// usage: input words enter on push/full with in_item; a word is taken at a
// clock edge with push high and full low. func 1 writes table_word at
// table_index into the random table; func 0 hashes key_byte, restart
// beginning a new key. every input word yields one result word on out_item,
// shown while empty is low and taken at an edge with pop high.
// path: op queue, registered table read, xor into the hash, result queue.
// throughput: one word per cycle while the receiver keeps popping, set by
// the single table read port and the xor into the running hash.
// the front tracks the base and feeds a 4-entry op queue; the back reads
// the table and fills a 4-entry result queue. when the receiver stalls the
// result queue fills, the back stops issuing, the op queue fills and full
// rises. reset empties both queues and clears the base and the hash; the
// table holds no defined value until written and is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module h3_tabulation_hash #(
  parameter int SYMBOLS   = 256,
  parameter int KEY_BYTES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire h3th_pkg::in_item_t in_item,
  output logic                   empty,
  input  wire logic              pop,
  output h3th_pkg::out_item_t     out_item
);

  localparam int TABLE_WORDS = SYMBOLS * KEY_BYTES;
  localparam int QDEPTH      = 4;
  localparam int QCW         = $clog2(QDEPTH + 1);
  localparam int OPW         = $bits(h3th_pkg::op_t);
  localparam int RESW        = $bits(h3th_pkg::out_item_t);

  logic                in_acc;
  h3th_pkg::op_t        front_op;
  h3th_pkg::op_t        back_op;
  logic [OPW-1:0]      back_op_bits;
  logic                op_empty;
  logic                op_pop;
  logic [QCW-1:0]      op_count;
  logic                res_push;
  h3th_pkg::out_item_t  res;
  logic [RESW-1:0]     out_bits;
  logic                out_full;
  logic [QCW-1:0]      out_count;

  assign in_acc   = push && !full;
  assign back_op  = h3th_pkg::op_t'(back_op_bits);
  assign out_item = h3th_pkg::out_item_t'(out_bits);

  h3th_front #(
    .TABLE_WORDS(TABLE_WORDS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(in_acc),
    .item  (in_item),
    .op    (front_op)
  );

  h3th_fifo #(
    .W    (OPW),
    .DEPTH(QDEPTH)
  ) u_op_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_acc),
    .wr_data(front_op),
    .rd_en  (op_pop),
    .rd_data(back_op_bits),
    .full   (full),
    .empty  (op_empty),
    .count  (op_count)
  );

  h3th_back #(
    .TABLE_WORDS(TABLE_WORDS),
    .OUT_DEPTH  (QDEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (back_op),
    .op_empty (op_empty),
    .op_pop   (op_pop),
    .out_count(out_count),
    .res_push (res_push),
    .res      (res)
  );

  h3th_fifo #(
    .W    (RESW),
    .DEPTH(QDEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_data(res),
    .rd_en  (pop),
    .rd_data(out_bits),
    .full   (out_full),
    .empty  (empty),
    .count  (out_count)
  );

  // a result word never arrives at a full result queue
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !out_full)
    else $error("result pushed into full queue");

  // every issued op yields a result in the following cycle
  a_issue_res: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop |=> res_push)
    else $error("issued op produced no result");

  // the back only issues from a non-empty op queue
  a_issue_src: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop |-> (op_count != '0))
    else $error("issue from empty op queue");

endmodule

`default_nettype wire
